@@ rtl/udp_media_payload_classifier_defines.svh @@
// Assertion helpers shared by the classifier RTL.
`ifndef UDP_MEDIA_PAYLOAD_CLASSIFIER_DEFINES_SVH
`define UDP_MEDIA_PAYLOAD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define UMPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define UMPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/umpc_pkg.sv @@
package umpc_pkg;

    // payload kinds
    localparam logic [2:0] KIND_UNDECIDED = 3'd0;
    localparam logic [2:0] KIND_UDP_TS    = 3'd1;
    localparam logic [2:0] KIND_RTP_TS    = 3'd2;
    localparam logic [2:0] KIND_CTP       = 3'd3;
    localparam logic [2:0] KIND_VIDEO     = 3'd4;
    localparam logic [2:0] KIND_AUDIO     = 3'd5;
    localparam logic [2:0] KIND_ANC       = 3'd6;
    localparam logic [2:0] KIND_BYTES     = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_CTP_THRESH   = 2'd0;
    localparam logic [1:0] REG_MEDIA_THRESH = 2'd1;
    localparam logic [1:0] REG_UNKNOWN_LIM  = 2'd2;

    localparam logic [7:0] CTP_THRESH_RST   = 8'd2;
    localparam logic [7:0] MEDIA_THRESH_RST = 8'd4;
    localparam logic [7:0] UNKNOWN_LIM_RST  = 8'd12;

    localparam logic [16:0] TS_SIZE     = 17'd188;
    localparam logic [7:0]  TS_SYNC     = 8'h47;
    localparam logic [15:0] RTP_HDR_LEN = 16'd12;
    localparam logic [3:0]  RTP_OFFSET  = 4'd12;
    localparam logic [7:0]  RTP_V_MASK  = 8'hcf;
    localparam logic [7:0]  RTP_V2      = 8'h80;
    localparam logic [7:0]  RTP_PT_MASK = 8'h7f;
    localparam logic [7:0]  PT_CTP      = 8'd97;
    localparam logic [7:0]  PT_VIDEO    = 8'd96;
    localparam logic [7:0]  PT_AUDIO    = 8'd98;
    localparam logic [7:0]  PT_ANC      = 8'd100;

    // x / 47 for x < 2^14 as (x * 22311) >> 20
    localparam logic [14:0] DIV47_MUL   = 15'd22311;
    localparam int          DIV47_SHIFT = 20;

    typedef struct packed {
        logic [7:0] ctp_thresh;
        logic [7:0] media_thresh;
        logic [7:0] unknown_lim;
    } cfg_t;

    // contents of the input register
    typedef struct packed {
        logic [15:0] len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b12;
        logic [8:0]  q_raw;   // len / 188
        logic [8:0]  q_rtp;   // (len - 12) / 188, zero for short lengths
    } item_t;

    typedef struct packed {
        logic [8:0] count;
        logic [3:0] offset;
        logic [2:0] kind;
    } result_t;

endpackage

@@ rtl/umpc_div188.sv @@
module umpc_div188
    import umpc_pkg::*;
(
    input  logic [15:0] dividend,
    output logic [8:0]  quotient
);

    logic [28:0] prod;

    // drop the factor of four, then reciprocal-multiply by 1/47
    assign prod     = 29'(dividend[15:2]) * 29'(DIV47_MUL);
    assign quotient = prod[DIV47_SHIFT +: 9];

endmodule

@@ rtl/umpc_classify.sv @@
`include "udp_media_payload_classifier_defines.svh"

module umpc_classify
    import umpc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic [2:0] kind_reg, kind_next;
    logic [7:0] ctp_reg, ctp_next;
    logic [7:0] video_reg, video_next;
    logic [7:0] audio_reg, audio_next;
    logic [7:0] anc_reg, anc_next;
    logic [7:0] unk_reg, unk_next;

    logic [16:0] raw_prod, rtp_prod;
    logic [15:0] rest;
    logic        raw_ts, rtp_ts, rtp_hdr, fall_through;
    logic [7:0]  pt;
    logic [7:0]  ctp_inc, video_inc, audio_inc, anc_inc, unk_inc;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hff) ? v : v + 8'd1;
    endfunction

    assign raw_prod = 17'(item.q_raw) * TS_SIZE;
    assign rtp_prod = 17'(item.q_rtp) * TS_SIZE;
    assign rest     = item.len - RTP_HDR_LEN;

    assign raw_ts = (item.q_raw != 9'd0) && (raw_prod == {1'b0, item.len})
                 && (item.b0 == TS_SYNC);
    assign rtp_ts = (item.len > RTP_HDR_LEN) && (item.q_rtp != 9'd0)
                 && (rtp_prod == {1'b0, rest}) && (item.b12 == TS_SYNC);

    assign rtp_hdr = (item.b0 & RTP_V_MASK) == RTP_V2;
    assign pt      = item.b1 & RTP_PT_MASK;

    assign ctp_inc   = sat_inc(ctp_reg);
    assign video_inc = sat_inc(video_reg);
    assign audio_inc = sat_inc(audio_reg);
    assign anc_inc   = sat_inc(anc_reg);
    assign unk_inc   = sat_inc(unk_reg);

    always_comb begin
        kind_next    = kind_reg;
        ctp_next     = ctp_reg;
        video_next   = video_reg;
        audio_next   = audio_reg;
        anc_next     = anc_reg;
        unk_next     = unk_reg;
        fall_through = 1'b0;
        if (kind_reg == KIND_UNDECIDED) begin
            if (raw_ts) begin
                kind_next = KIND_UDP_TS;
            end else if (rtp_ts) begin
                kind_next = KIND_RTP_TS;
            end else begin
                fall_through = 1'b1;
                if (rtp_hdr && pt == PT_CTP) begin
                    ctp_next = ctp_inc;
                    if (ctp_inc > cfg.ctp_thresh) begin
                        kind_next    = KIND_CTP;
                        fall_through = 1'b0;
                    end
                end else if (rtp_hdr && pt == PT_VIDEO) begin
                    video_next = video_inc;
                    if (video_inc > cfg.media_thresh) begin
                        kind_next    = KIND_VIDEO;
                        fall_through = 1'b0;
                    end
                end else if (rtp_hdr && pt == PT_AUDIO) begin
                    audio_next = audio_inc;
                    if (audio_inc > cfg.media_thresh) begin
                        kind_next    = KIND_AUDIO;
                        fall_through = 1'b0;
                    end
                end else if (rtp_hdr && pt == PT_ANC) begin
                    anc_next = anc_inc;
                    if (anc_inc > cfg.media_thresh) begin
                        kind_next    = KIND_ANC;
                        fall_through = 1'b0;
                    end
                end else begin
                    ctp_next = 8'd0;
                end
                // unknown count compares its old value, then bumps
                if (fall_through) begin
                    unk_next = unk_inc;
                    if (unk_reg > cfg.unknown_lim) begin
                        kind_next = KIND_BYTES;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_UNDECIDED;
            ctp_reg   <= 8'd0;
            video_reg <= 8'd0;
            audio_reg <= 8'd0;
            anc_reg   <= 8'd0;
            unk_reg   <= 8'd0;
        end else if (advance) begin
            kind_reg  <= kind_next;
            ctp_reg   <= ctp_next;
            video_reg <= video_next;
            audio_reg <= audio_next;
            anc_reg   <= anc_next;
            unk_reg   <= unk_next;
        end
    end

    always_comb begin
        result.kind   = kind_next;
        result.offset = (kind_next == KIND_RTP_TS) ? RTP_OFFSET : 4'd0;
        result.count  = (kind_next == KIND_RTP_TS) ? item.q_rtp : item.q_raw;
    end

    `UMPC_ASSERT_NXT(a_kind_latched, kind_reg != KIND_UNDECIDED,
        kind_reg == $past(kind_reg), "latched kind changed")
    `UMPC_ASSERT_NXT(a_unknown_frozen, kind_reg != KIND_UNDECIDED,
        $stable(unk_reg) && $stable(ctp_reg), "counters moved after decision")

endmodule

@@ rtl/udp_media_payload_classifier.sv @@
// UDP media payload classifier.
// Slave stream s_*: one word per UDP datagram, carrying the payload length and
// the payload bytes at offsets 0, 1, 12, 188, 200, 376 and 388. Master stream
// m_*: one word per input word, in order, with the latched payload kind, the
// payload offset (12 for RTP-wrapped TS) and the TS packet count.
// Config port: cfg_we writes cfg_data[7:0] into register cfg_index (0 CTP
// match threshold, 1 media match threshold, 2 unknown limit); other indexes
// are ignored. Write only while the block is idle.
// An accepted word passes the input register, then the result register, before
// it shows on m_tvalid and m_tdata. Throughput: one word per cycle while
// m_tready does not stall; the classify step and its counter update sit
// between the two registers.
// A stalled m_tready holds the result register; one more word is taken into
// the input register, after which s_tready drops until the result drains.
// Reset (aresetn low, synchronous) empties both registers, clears the kind
// back to undecided, zeroes all match counters and restores the registers
// to their defaults (2, 4, 12).
`include "udp_media_payload_classifier_defines.svh"

module udp_media_payload_classifier
    import umpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // datagram summaries
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] payload_length, [23:16] byte_at_0, [31:24] byte_at_1,
    // [39:32] byte_at_12, [47:40] byte_at_188, [55:48] byte_at_200,
    // [63:56] byte_at_376, [71:64] byte_at_388
    input  logic [71:0] s_tdata,
    // classification results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] payload_kind, [6:3] payload_offset, [15:7] ts_packet_count
    output logic [15:0] m_tdata
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    item_t       in_reg, in_next;
    logic        out_valid_reg;
    result_t     out_reg, result;
    logic        advance, s_accept;
    logic [15:0] s_len, rtp_rest;

    // Configuration registers; later bytes (offsets 188 and up) are not
    // needed: one sync byte at the first boundary decides TS.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ctp_thresh   <= CTP_THRESH_RST;
            cfg_reg.media_thresh <= MEDIA_THRESH_RST;
            cfg_reg.unknown_lim  <= UNKNOWN_LIM_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CTP_THRESH:   cfg_reg.ctp_thresh   <= cfg_data;
                REG_MEDIA_THRESH: cfg_reg.media_thresh <= cfg_data;
                REG_UNKNOWN_LIM:  cfg_reg.unknown_lim  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Move a word from the input register to the result register whenever
    // the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Both divisions by 188 happen ahead of the input register, so the
    // classify step only multiplies back by the constant to check remainders.
    assign s_len    = s_tdata[15:0];
    assign rtp_rest = (s_len >= RTP_HDR_LEN) ? s_len - RTP_HDR_LEN : 16'd0;

    umpc_div188 u_div_raw (
        .dividend (s_len),
        .quotient (in_next.q_raw)
    );

    umpc_div188 u_div_rtp (
        .dividend (rtp_rest),
        .quotient (in_next.q_rtp)
    );

    assign in_next.len = s_len;
    assign in_next.b0  = s_tdata[23:16];
    assign in_next.b1  = s_tdata[31:24];
    assign in_next.b12 = s_tdata[39:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= in_next;
        end
    end

    // Classify against the latched kind and counters; state updates on advance.
    umpc_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `UMPC_ASSERT_IMP(a_no_overrun, in_valid_reg && !advance, !s_tready,
        "input register overwritten while full")
    `UMPC_ASSERT_NXT(a_advance_fills, advance, out_valid_reg,
        "advanced word missing from result register")
    `UMPC_ASSERT_IMP(a_offset_kind, out_valid_reg,
        (out_reg.kind == KIND_RTP_TS) == (out_reg.offset == RTP_OFFSET),
        "payload offset disagrees with kind")

endmodule
